// ----- design/hamd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamd_pkg
// Shared types and constants for the add/multiply/divide unit.
// ----------------------------------------------------------------------------
package hamd_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned DivSteps  = DataWidth;
  // pre stage + one stage per quotient bit + output register
  localparam int unsigned Latency   = DivSteps + 2;

  typedef enum logic [2:0] {
    FnAdd  = 3'd0,
    FnSub  = 3'd1,
    FnMulu = 3'd2,
    FnDiv  = 3'd3,
    FnDivu = 3'd4
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [DataWidth-1:0] operand_a;
    logic [DataWidth-1:0] operand_b;
  } item_t;

  typedef struct packed {
    logic [DataWidth-1:0] sum_word;
    logic                 carry_out;
    logic [DataWidth-1:0] hi_word;
    logic [DataWidth-1:0] lo_word;
    logic                 zero_divisor;
  } result_t;

  // hi: partial remainder or product high; lo: quotient bits or product low / sum
  typedef struct packed {
    func_e                func;
    logic [DataWidth-1:0] hi;
    logic [DataWidth-1:0] lo;
    logic [DataWidth-1:0] dvs;
    logic                 carry;
    logic                 neg_q;
    logic                 neg_r;
    logic                 zd;
  } stage_t;

  function automatic logic is_div(func_e f);
    return (f == FnDiv) || (f == FnDivu);
  endfunction

endpackage

// ----- design/hilo_add_mul_div_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilo_add_mul_div_unit
// 32-bit add, subtract, unsigned multiply and signed/unsigned divide.
// ----------------------------------------------------------------------------
// Every operation passes from start to done_o through an input register,
// the 32-stage divider pipeline (one quotient bit per stage) and an output
// register. A new item may start in every cycle; busy is high only in the
// first cycle after reset. Results appear for one cycle on done_o and must
// be taken then, since the receiver cannot stall the unit.
module hilo_add_mul_div_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hamd_pkg::item_t   item_i,
  output logic              done_o,
  output hamd_pkg::result_t result_o
);
  import hamd_pkg::*;

  logic   busy_q;
  logic   accept;
  logic   vld [DivSteps+1];
  stage_t stg [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  hamd_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .valid_o (vld[0]),
    .stage_o (stg[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    hamd_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .stage_i (stg[i]),
      .valid_o (vld[i+1]),
      .stage_o (stg[i+1])
    );
  end

  hamd_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld[DivSteps]),
    .stage_i  (stg[DivSteps]),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without matching item");

  a_zd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.zero_divisor |->
      (result_o.hi_word == '0) && (result_o.lo_word == '0) && (result_o.sum_word == '0))
    else $error("zero divisor result not cleared");

  a_addsub_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.carry_out |->
      (result_o.hi_word == '0) && (result_o.lo_word == '0) && !result_o.zero_divisor)
    else $error("carry on non add/sub result");

endmodule

// ----- design/hamd_pre.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamd_pre
// Front stage: adder, multiplier and divide operand conditioning.
// ----------------------------------------------------------------------------
module hamd_pre (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  hamd_pkg::item_t item_i,
  output logic           valid_o,
  output hamd_pkg::stage_t stage_o
);
  import hamd_pkg::*;

  logic             valid_q;
  stage_t           stage_d, stage_q;
  logic [DataWidth:0]     add_res;
  logic [DataWidth-1:0]   addend;
  logic [2*DataWidth-1:0] prod;
  logic                   sa, sb;

  always_comb begin
    sa      = item_i.operand_a[DataWidth-1];
    sb      = item_i.operand_b[DataWidth-1];
    addend  = (item_i.func == FnSub) ? (~item_i.operand_b + DataWidth'(1))
                                     : item_i.operand_b;
    add_res = {1'b0, item_i.operand_a} + {1'b0, addend};
    prod    = {{DataWidth{1'b0}}, item_i.operand_a} *
              {{DataWidth{1'b0}}, item_i.operand_b};
    stage_d       = '0;
    stage_d.func  = item_i.func;
    stage_d.dvs   = item_i.operand_b;
    stage_d.zd    = (item_i.operand_b == '0);
    case (item_i.func)
      FnAdd, FnSub: begin
        stage_d.lo    = add_res[DataWidth-1:0];
        stage_d.carry = add_res[DataWidth];
      end
      FnMulu: begin
        stage_d.hi = prod[2*DataWidth-1:DataWidth];
        stage_d.lo = prod[DataWidth-1:0];
      end
      FnDiv: begin
        stage_d.lo    = sa ? (~item_i.operand_a + DataWidth'(1)) : item_i.operand_a;
        stage_d.dvs   = sb ? (~item_i.operand_b + DataWidth'(1)) : item_i.operand_b;
        stage_d.neg_q = sa ^ sb;
        stage_d.neg_r = sa;
      end
      FnDivu: begin
        stage_d.lo = item_i.operand_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- design/hamd_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamd_div_stage
// One restoring division step, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hamd_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  hamd_pkg::stage_t stage_i,
  output logic             valid_o,
  output hamd_pkg::stage_t stage_o
);
  import hamd_pkg::*;

  logic               valid_q;
  stage_t             stage_d, stage_q;
  logic [DataWidth:0] rem_sh, diff;

  always_comb begin
    rem_sh  = {stage_i.hi, stage_i.lo[DataWidth-1]};
    diff    = rem_sh - {1'b0, stage_i.dvs};
    stage_d = stage_i;
    if (is_div(stage_i.func)) begin
      if (!diff[DataWidth]) begin
        stage_d.hi = diff[DataWidth-1:0];
        stage_d.lo = {stage_i.lo[DataWidth-2:0], 1'b1};
      end else begin
        stage_d.hi = rem_sh[DataWidth-1:0];
        stage_d.lo = {stage_i.lo[DataWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- design/hamd_post.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamd_post
// Sign correction, result selection and output register.
// ----------------------------------------------------------------------------
module hamd_post (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hamd_pkg::stage_t  stage_i,
  output logic              valid_o,
  output hamd_pkg::result_t result_o
);
  import hamd_pkg::*;

  logic    valid_q;
  result_t res_d, res_q;

  always_comb begin
    res_d = '0;
    case (stage_i.func)
      FnAdd, FnSub: begin
        res_d.sum_word  = stage_i.lo;
        res_d.carry_out = stage_i.carry;
      end
      FnMulu: begin
        res_d.hi_word = stage_i.hi;
        res_d.lo_word = stage_i.lo;
      end
      FnDiv, FnDivu: begin
        if (stage_i.zd) begin
          res_d.zero_divisor = 1'b1;
        end else begin
          res_d.lo_word = stage_i.neg_q ? (~stage_i.lo + DataWidth'(1)) : stage_i.lo;
          res_d.hi_word = stage_i.neg_r ? (~stage_i.hi + DataWidth'(1)) : stage_i.hi;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ----- tb/hilo_add_mul_div_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilo_add_mul_div_unit_tb
// Drives add, subtract, multiply, divide and unused function codes into the
// unit, predicts each result with a behavioral model and checks results in order.
// ----------------------------------------------------------------------------
module hilo_add_mul_div_unit_tb;
  import hamd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;

  class alu_scoreboard;
    result_t pending_q[$];
    int      mismatches;

    function result_t compute(item_t it);
      result_t r;
      logic [32:0] s;
      logic [63:0] p;
      logic [31:0] a, b, ma, mb, q;
      r = '0;
      a = it.operand_a;
      b = it.operand_b;
      case (it.func)
        FnAdd: begin
          s = {1'b0, a} + {1'b0, b};
          r.sum_word = s[31:0];
          r.carry_out = s[32];
        end
        FnSub: begin
          s = {1'b0, a} + {1'b0, (~b + 32'd1)};
          r.sum_word = s[31:0];
          r.carry_out = s[32];
        end
        FnMulu: begin
          p = {32'd0, a} * {32'd0, b};
          r.hi_word = p[63:32];
          r.lo_word = p[31:0];
        end
        FnDivu: begin
          if (b == 0) r.zero_divisor = 1'b1;
          else begin
            r.lo_word = a / b;
            r.hi_word = a % b;
          end
        end
        FnDiv: begin
          if (b == 0) r.zero_divisor = 1'b1;
          else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            if (a[31] ^ b[31]) q = -q;
            r.lo_word = q;
            r.hi_word = a - b * q;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_item(item_t it);
      pending_q.push_back(compute(it));
    endfunction

    function void check_result(result_t act);
      result_t exp;
      bit bad;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", act);
        return;
      end
      exp = pending_q.pop_front();
      bad = (exp.sum_word != act.sum_word) || (exp.carry_out != act.carry_out) ||
            (exp.hi_word != act.hi_word) || (exp.lo_word != act.lo_word) ||
            (exp.zero_divisor != act.zero_divisor);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp sum=%h c=%b hi=%h lo=%h zd=%b act sum=%h c=%b hi=%h lo=%h zd=%b",
                   exp.sum_word, exp.carry_out, exp.hi_word, exp.lo_word, exp.zero_divisor,
                   act.sum_word, act.carry_out, act.hi_word, act.lo_word, act.zero_divisor);
      end
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  alu_scoreboard sb;
  int unsigned   idle_pct;
  int unsigned   quiet_cycles;

  hilo_add_mul_div_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_item(item_i);
      if (done_o) sb.check_result(result_o);
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("hilo_add_mul_div_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(16);
      5: return -$urandom_range(16);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.func = func_e'($urandom_range(9) == 0 ? $urandom_range(7, 5) : $urandom_range(4));
      it.operand_a = pick_operand();
      it.operand_b = pick_operand();
      send_item(it);
    end
  endtask

  task automatic send_directed();
    logic [31:0] vals [6] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'd7};
    item_t it;
    for (int f = 0; f < 8; f++) begin
      for (int k = 0; k < 3; k++) begin
        it.func = func_e'(f);
        it.operand_a = vals[(k * 2 + f) % 6];
        it.operand_b = vals[(k * 3 + 1) % 6];
        send_item(it);
      end
    end
    it.func = FnDiv;
    it.operand_a = 32'h8000_0000;
    it.operand_b = 32'hFFFF_FFFF;
    send_item(it);
    it.operand_a = -32'd7;
    it.operand_b = 32'd2;
    send_item(it);
    it.func = FnSub;
    it.operand_a = 32'd5;
    it.operand_b = 32'd0;
    send_item(it);
  endtask

  initial begin
    sb = new();
    start = 1'b0;
    item_i = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    idle_pct = 0;  send_random(500);
    idle_pct = 78; send_random(350);
    idle_pct = 36; send_random(300);
    idle_pct = 0;  send_random(270);
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (sb.mismatches == 0) $display("hilo_add_mul_div_unit_tb: PASS");
    else $display("hilo_add_mul_div_unit_tb: FAIL");
    $finish;
  end

endmodule
